>>> sv/dcorr_pkg.sv
// dcorr_pkg: shared types, register indexes and helpers for the disparity correlator
// no dependencies; imported by every module of the block

package dcorr_pkg;

    localparam int DATA_W     = 8;   // sample width
    localparam int SUM_W      = 16;  // wrapping accumulator width
    localparam int OUT_DISP_W = 3;   // disparity field on the result bus
    localparam int SHIFT_W    = 4;   // result shift register width
    localparam int CFG_W      = 9;   // widest configuration register
    localparam int CFG_IDX_W  = 3;   // configuration register index
    localparam int CMP_W      = 16;  // width used for count compares

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DISP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT    = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_EMIT  = 4'b1000
    } seq_state_t;

    // accumulator memory commands from the sequencer
    typedef struct packed {
        logic mac_rd;   // read entry for a multiply-accumulate
        logic emit_rd;  // read entry for a result
        logic clear;    // drop all entries back to zero
    } acc_ctrl_t;

    // one result on its way out
    typedef struct packed {
        logic [OUT_DISP_W-1:0] disp;
        logic [DATA_W-1:0]     corr;
        logic                  last_pix;
        logic                  eof;
    } out_item_t;

    // zero acts as one, oversized values saturate
    function automatic logic [CMP_W-1:0] clamp_count(input logic [CMP_W-1:0] v,
                                                     input logic [CMP_W-1:0] maxv);
        logic [CMP_W-1:0] r;
        if (v == '0)
            r = CMP_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> sv/dcorr_hist_mem.sv
// dcorr_hist_mem: right-sample history, one write port and one registered read port
// uses dcorr_pkg for the sample width

module dcorr_hist_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [dcorr_pkg::DATA_W-1:0]  wdata,
    input  logic                          re,
    input  logic [ADDR_W-1:0]             raddr,
    output logic [dcorr_pkg::DATA_W-1:0]  rdata
);
    import dcorr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/dcorr_accum.sv
// dcorr_accum: per-disparity accumulator memory with multiply-accumulate write-back
// uses dcorr_pkg; fed by the sequencer and the history memory read data

module dcorr_accum #(
    parameter int MAX_DISP = 8,
    parameter int DISP_W   = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dcorr_pkg::acc_ctrl_t                ctrl,
    input  logic [DISP_W-1:0]                   rd_idx,
    input  logic                                upd,       // disparity in range for this column
    input  logic signed [dcorr_pkg::DATA_W-1:0] left_value,
    input  logic [dcorr_pkg::DATA_W-1:0]        hist_rdata,
    output logic [dcorr_pkg::SUM_W-1:0]         emit_sum
);
    import dcorr_pkg::*;

    logic [SUM_W-1:0]  acc_mem [MAX_DISP];
    logic [MAX_DISP-1:0] valid_reg;
    logic [SUM_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic              mac_pend_reg;
    logic              upd_reg;
    logic [DISP_W-1:0] widx_reg;

    logic [SUM_W-1:0]        acc_base;
    logic signed [SUM_W-1:0] prod;
    logic [SUM_W-1:0]        sum;
    logic                    wr_en;

    // entry not written since the last clear reads as zero
    assign acc_base = rd_valid_reg ? rd_data_reg : '0;
    assign prod     = $signed({{(SUM_W-DATA_W){left_value[DATA_W-1]}}, left_value})
                    * $signed({{(SUM_W-DATA_W){hist_rdata[DATA_W-1]}}, hist_rdata});
    assign sum      = acc_base + SUM_W'(prod);
    assign wr_en    = mac_pend_reg && upd_reg;
    assign emit_sum = acc_base;

    always_ff @(posedge clk)
    begin
        if (ctrl.mac_rd || ctrl.emit_rd)
        begin
            rd_data_reg <= acc_mem[rd_idx];
        end
        if (wr_en)
        begin
            acc_mem[widx_reg] <= sum;
        end
        upd_reg  <= upd;
        widx_reg <= rd_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            mac_pend_reg <= 1'b0;
        end
        else
        begin
            mac_pend_reg <= ctrl.mac_rd;
            if (ctrl.mac_rd || ctrl.emit_rd)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
            if (ctrl.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[widx_reg] <= 1'b1;
            end
        end
    end

endmodule

>>> sv/dcorr_out_fifo.sv
// dcorr_out_fifo: result scaling and a two-entry output queue toward the stream port
// uses dcorr_pkg for the result item type

module dcorr_out_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [dcorr_pkg::OUT_DISP_W-1:0]  push_disp,
    input  logic                              push_last_pix,
    input  logic                              push_eof,
    input  logic [dcorr_pkg::SUM_W-1:0]       push_sum,
    input  logic [dcorr_pkg::SHIFT_W-1:0]     sum_shift,
    output logic [1:0]                        count,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output dcorr_pkg::out_item_t              head
);
    import dcorr_pkg::*;

    out_item_t         entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic signed [SUM_W-1:0] shifted;
    out_item_t         new_item;
    logic              pop;

    // arithmetic shift, then keep the low byte
    assign shifted = $signed(push_sum) >>> sum_shift;

    always_comb
    begin
        new_item.disp     = push_disp;
        new_item.corr     = shifted[DATA_W-1:0];
        new_item.last_pix = push_last_pix;
        new_item.eof      = push_eof;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> sv/disparity_correlation_int8.sv
// disparity_correlation_int8: top level, sequencer, raster counters and configuration
// uses dcorr_pkg, dcorr_hist_mem, dcorr_accum and dcorr_out_fifo

// Horizontal-disparity correlation of two int8 feature maps. Each input request
// carries one channel of the current pixel (left sample in s_tdata[7:0], right in
// s_tdata[15:8]); pixels come in raster order with channels innermost. The right
// samples of the last MAX_DISP columns sit in a history RAM, and one shared
// multiply-accumulate walks the disparities, reading the history RAM and an
// accumulator RAM and writing the new sum back in the following cycle. An input
// request is handled as accept, one history/accumulator read per disparity and
// one write-back drain. On a pixel's last channel the block then reads out the
// num_disp sums into a two-entry output queue, pausing the reads while it has no
// room, so the next pixel is accepted while the last results are still waiting.
// Each result is the 16-bit wrapping sum shifted right arithmetically by the
// programmed shift and cut to 8 bits; disparities beyond the current column give
// zero. No clearing pass is needed after reset. Configuration
// (cfg_we/cfg_addr/cfg_wdata) must only be written while the block is idle.

module disparity_correlation_int8 #(
    parameter int MAX_DISP     = 8,
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_ROWS     = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [dcorr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [dcorr_pkg::CFG_W-1:0]       cfg_wdata,
    // input requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [7:0] left_value, [15:8] right_value
    // result requests
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [2:0] disparity, [10:3] corr_value, zero pad
    output logic                              m_tlast,   // last_of_pixel
    output logic                              m_tuser    // end_of_frame
);
    import dcorr_pkg::*;

    localparam int DISP_W     = (MAX_DISP > 1) ? $clog2(MAX_DISP) : 1;
    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int HIST_DEPTH = MAX_DISP * MAX_CHANNELS;
    localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // configuration registers
    logic [6:0]         num_channels_reg;
    logic [3:0]         num_disp_reg;
    logic [8:0]         frame_width_reg;
    logic [8:0]         frame_rows_reg;
    logic [SHIFT_W-1:0] sum_shift_reg;

    // effective counts
    logic [CMP_W-1:0] nch;
    logic [CMP_W-1:0] nd;
    logic [CMP_W-1:0] nw;
    logic [CMP_W-1:0] nr;

    assign nch = clamp_count(CMP_W'(num_channels_reg), CMP_W'(MAX_CHANNELS));
    assign nd  = clamp_count(CMP_W'(num_disp_reg), CMP_W'(MAX_DISP));
    assign nw  = clamp_count(CMP_W'(frame_width_reg), CMP_W'(MAX_WIDTH));
    assign nr  = clamp_count(CMP_W'(frame_rows_reg), CMP_W'(MAX_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= 7'd1;
            num_disp_reg     <= 4'd5;
            frame_width_reg  <= 9'd88;
            frame_rows_reg   <= 9'd112;
            sum_shift_reg    <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NUM_CHANNELS: num_channels_reg <= cfg_wdata[6:0];
                REG_NUM_DISP:     num_disp_reg     <= cfg_wdata[3:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[8:0];
                REG_FRAME_ROWS:   frame_rows_reg   <= cfg_wdata[8:0];
                REG_OUT_SHIFT:    sum_shift_reg    <= cfg_wdata[SHIFT_W-1:0];
                default:          ; // unused index
            endcase
        end
    end

    // sequencer and raster state
    seq_state_t        state_reg, state_next;
    logic [DISP_W-1:0] d_reg, d_next;
    logic [CH_W-1:0]   chan_cnt_reg, chan_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [DISP_W-1:0] slot_cnt_reg, slot_cnt_next;   // column modulo MAX_DISP

    // snapshot of the request under work
    logic signed [DATA_W-1:0] left_reg;
    logic [CH_W-1:0]          item_ch_reg;
    logic [DISP_W-1:0]        item_slot_reg;
    logic [COL_W-1:0]         item_col_reg;
    logic                     item_last_ch_reg;
    logic                     item_eof_reg;

    // result read in flight
    logic                  emit_pend_reg;
    logic [OUT_DISP_W-1:0] emit_disp_reg;
    logic                  emit_last_reg;
    logic                  emit_eof_reg;

    logic        accept;
    logic        last_ch;
    logic        last_col;
    logic        last_row;
    logic        d_is_last;
    logic        emit_go;
    logic [1:0]  fifo_count;
    logic [CMP_W-1:0] d_ext;

    acc_ctrl_t   acc_ctrl;
    logic        upd;

    logic [ADDR_W-1:0] hist_waddr;
    logic [ADDR_W-1:0] hist_raddr;
    logic [DISP_W:0]   rd_slot_wide;
    logic [DISP_W-1:0] rd_slot;
    logic [DATA_W-1:0] hist_rdata;
    logic [SUM_W-1:0]  emit_sum;
    out_item_t         head;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign d_ext     = CMP_W'(d_reg);
    assign d_is_last = (d_ext + CMP_W'(1) >= nd);
    assign emit_go   = (state_reg == ST_EMIT)
                    && ({1'b0, fifo_count} + {2'b00, emit_pend_reg} < 3'd2);

    // end-of-pixel, end-of-row and end-of-frame tests for the arriving request
    assign last_ch  = (CMP_W'(chan_cnt_reg) + CMP_W'(1) >= nch);
    assign last_col = (CMP_W'(col_cnt_reg) + CMP_W'(1) >= nw);
    assign last_row = (CMP_W'(row_cnt_reg) + CMP_W'(1) >= nr);

    // history slot of column (col - d), wrapping inside MAX_DISP
    always_comb
    begin
        if (item_slot_reg >= d_reg)
            rd_slot_wide = {1'b0, item_slot_reg} - {1'b0, d_reg};
        else
            rd_slot_wide = {1'b0, item_slot_reg} + (DISP_W+1)'(MAX_DISP) - {1'b0, d_reg};
        rd_slot = rd_slot_wide[DISP_W-1:0];
    end

    assign hist_waddr = ADDR_W'(slot_cnt_reg) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(chan_cnt_reg);
    assign hist_raddr = ADDR_W'(rd_slot) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(item_ch_reg);

    // disparity only counts once the column has reached it
    assign upd = (CMP_W'(item_col_reg) >= d_ext);

    always_comb
    begin
        state_next    = state_reg;
        d_next        = d_reg;
        chan_cnt_next = chan_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        slot_cnt_next = slot_cnt_reg;
        acc_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    d_next     = '0;
                    state_next = ST_MAC;
                    if (!last_ch)
                    begin
                        chan_cnt_next = chan_cnt_reg + CH_W'(1);
                    end
                    else
                    begin
                        chan_cnt_next = '0;
                        if (last_col)
                        begin
                            col_cnt_next  = '0;
                            slot_cnt_next = '0;
                            row_cnt_next  = last_row ? '0 : row_cnt_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_cnt_next  = col_cnt_reg + COL_W'(1);
                            slot_cnt_next = (CMP_W'(slot_cnt_reg) + CMP_W'(1) >= CMP_W'(MAX_DISP))
                                          ? '0 : slot_cnt_reg + DISP_W'(1);
                        end
                    end
                end
            end
            ST_MAC:
            begin
                acc_ctrl.mac_rd = 1'b1;
                d_next          = d_reg + DISP_W'(1);
                if (d_is_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last write-back lands this cycle
                d_next     = '0;
                state_next = item_last_ch_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    acc_ctrl.emit_rd = 1'b1;
                    d_next           = d_reg + DISP_W'(1);
                    if (d_is_last)
                    begin
                        acc_ctrl.clear = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            d_reg         <= '0;
            chan_cnt_reg  <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            slot_cnt_reg  <= '0;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            d_reg         <= d_next;
            chan_cnt_reg  <= chan_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            slot_cnt_reg  <= slot_cnt_next;
            emit_pend_reg <= emit_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg         <= $signed(s_tdata[7:0]);
            item_ch_reg      <= chan_cnt_reg;
            item_slot_reg    <= slot_cnt_reg;
            item_col_reg     <= col_cnt_reg;
            item_last_ch_reg <= last_ch;
            item_eof_reg     <= last_col && last_row;
        end
        emit_disp_reg <= d_ext[OUT_DISP_W-1:0];
        emit_last_reg <= d_is_last;
        emit_eof_reg  <= d_is_last && item_eof_reg;
    end

    dcorr_hist_mem #(
        .DEPTH  (HIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hist (
        .clk   (clk),
        .we    (accept),
        .waddr (hist_waddr),
        .wdata (s_tdata[15:8]),
        .re    (acc_ctrl.mac_rd),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    dcorr_accum #(
        .MAX_DISP (MAX_DISP),
        .DISP_W   (DISP_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (acc_ctrl),
        .rd_idx     (d_reg),
        .upd        (upd),
        .left_value (left_reg),
        .hist_rdata (hist_rdata),
        .emit_sum   (emit_sum)
    );

    dcorr_out_fifo u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (emit_pend_reg),
        .push_disp     (emit_disp_reg),
        .push_last_pix (emit_last_reg),
        .push_eof      (emit_eof_reg),
        .push_sum      (emit_sum),
        .sum_shift     (sum_shift_reg),
        .count         (fifo_count),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .head          (head)
    );

    assign m_tdata = {5'b00000, head.corr, head.disp};
    assign m_tlast = head.last_pix;
    assign m_tuser = head.eof;

endmodule
